@@ rtl/wbps_pkg.sv @@
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int LEN_W       = 6;
   localparam int ADDR_W      = 64;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int PATTERN_W   = MAX_PATTERN * BYTE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_BASE_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_0    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_1    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_2    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_3    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WILDCARD     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH       = 3'd6;

   typedef logic [PATTERN_W-1:0] pattern_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

   // Compare outcome of one item, handed from the window to the report stage.
   typedef struct packed {
      logic              match;
      logic              last;
      logic [ADDR_W-1:0] offset;
   } scan_type;

endpackage

@@ rtl/wildcard_byte_pattern_scanner.sv @@
// Top level of the wildcard byte pattern scanner: config registers, cell chain, report stage.
//
// Scans a byte stream, one byte per item, against a pattern of up to 32 bytes in which
// wildcard bits mark positions that match anything. The first complete match of a range
// yields one result with found set and the start address (base address plus byte offset,
// modulo 2^64); a range that ends without a match, or any range with a zero pattern length,
// yields one result with found clear and address zero at its last byte. Bytes after a match
// up to the last byte give nothing. The block takes one item every clock cycle unless the
// output stalls: each byte shifts into a chain of 32 cells, each comparing its byte against
// its pattern byte in parallel, and a result passes the window, hold and output registers.
// There is no clearing pass after reset. Write the registers only while no item is in flight.
module wildcard_byte_pattern_scanner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wbps_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wbps_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import wbps_pkg::*;

   logic [ADDR_W-1:0]      base_ff, base_in;
   pattern_type            pattern_ff, pattern_in;
   logic [MAX_PATTERN-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]       length_ff, length_in;

   logic              scan_valid_ff, scan_valid_in;
   logic              scan_last_ff, scan_last_in;
   logic [ADDR_W-1:0] seen_ff, seen_in;
   logic              clear_ff, clear_in;

   logic                   accept;
   logic                   scan_take;
   logic [LEN_W-1:0]       active_length;
   logic [BYTE_W-1:0]      chain [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hits;
   scan_type               scan_item;

   // Configuration registers
   always_comb begin
      base_in    = base_ff;
      pattern_in = pattern_ff;
      mask_in    = mask_ff;
      length_in  = length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_BASE_ADDRESS: base_in = csr_write_data;
            REG_PATTERN_0:    pattern_in[0*CSR_DATA_W +: CSR_DATA_W] = csr_write_data;
            REG_PATTERN_1:    pattern_in[1*CSR_DATA_W +: CSR_DATA_W] = csr_write_data;
            REG_PATTERN_2:    pattern_in[2*CSR_DATA_W +: CSR_DATA_W] = csr_write_data;
            REG_PATTERN_3:    pattern_in[3*CSR_DATA_W +: CSR_DATA_W] = csr_write_data;
            REG_WILDCARD:     mask_in = csr_write_data[MAX_PATTERN-1:0];
            REG_LENGTH:       length_in = csr_write_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign active_length = (length_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length_ff;

   // Window stage
   assign accept    = req_valid && req_ready;
   assign req_ready = !scan_valid_ff || scan_take;

   always_comb begin
      scan_valid_in = scan_valid_ff;
      scan_last_in  = scan_last_ff;
      seen_in       = seen_ff;
      clear_in      = clear_ff;
      if (accept) begin
         scan_valid_in = 1'b1;
         scan_last_in  = req_payload.last_byte;
         clear_in      = req_payload.last_byte;
         if (clear_ff) begin
            seen_in = ADDR_W'(1);
         end else if (seen_ff != '1) begin
            seen_in = seen_ff + ADDR_W'(1);
         end
      end else if (scan_take) begin
         scan_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         pattern_ff    <= '0;
         mask_ff       <= '0;
         length_ff     <= '0;
         scan_valid_ff <= 1'b0;
         seen_ff       <= '0;
         clear_ff      <= 1'b1;
      end else begin
         base_ff       <= base_in;
         pattern_ff    <= pattern_in;
         mask_ff       <= mask_in;
         length_ff     <= length_in;
         scan_valid_ff <= scan_valid_in;
         seen_ff       <= seen_in;
         clear_ff      <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_last_ff <= scan_last_in;
   end

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [BYTE_W-1:0] up_byte;
      logic              clear_window;

      if (k == 0) begin : g_head
         assign up_byte      = req_payload.data_byte;
         assign clear_window = 1'b0;
      end else begin : g_body
         assign up_byte      = chain[k-1];
         assign clear_window = clear_ff;
      end

      wbps_cell u_cell (
         .clock         (clock),
         .shift_en      (accept),
         .clear_window  (clear_window),
         .up_byte       (up_byte),
         .cell_idx      (IDX_W'(k)),
         .pattern       (pattern_ff),
         .wildcard_mask (mask_ff),
         .active_length (active_length),
         .down_byte     (chain[k]),
         .hit           (hits[k])
      );
   end

   assign scan_item.match  = (&hits) && (active_length != '0)
                             && (seen_ff >= ADDR_W'(active_length));
   assign scan_item.last   = scan_last_ff;
   assign scan_item.offset = seen_ff - ADDR_W'(active_length);

   wbps_report u_report (
      .clock        (clock),
      .reset        (reset),
      .scan_valid   (scan_valid_ff),
      .scan_item    (scan_item),
      .scan_take    (scan_take),
      .base_address (base_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

@@ rtl/wbps_cell.sv @@
// One window cell: holds a byte, passes it on, and checks it against its pattern byte.
module wbps_cell (
   input  logic                             clock,
   input  logic                             shift_en,
   input  logic                             clear_window,
   input  logic [wbps_pkg::BYTE_W-1:0]      up_byte,
   input  logic [wbps_pkg::IDX_W-1:0]       cell_idx,
   input  wbps_pkg::pattern_type            pattern,
   input  logic [wbps_pkg::MAX_PATTERN-1:0] wildcard_mask,
   input  logic [wbps_pkg::LEN_W-1:0]       active_length,
   output logic [wbps_pkg::BYTE_W-1:0]      down_byte,
   output logic                             hit
);
   import wbps_pkg::*;

   logic [BYTE_W-1:0] window_byte_ff;
   logic [BYTE_W-1:0] window_byte_in;
   logic [LEN_W-1:0]  pat_pos;
   logic [IDX_W-1:0]  pat_idx;
   logic              in_use;

   always_comb begin
      window_byte_in = window_byte_ff;
      if (shift_en) begin
         window_byte_in = clear_window ? '0 : up_byte;
      end
   end

   always_ff @(posedge clock) begin
      window_byte_ff <= window_byte_in;
   end

   // Window entry k lines up with pattern byte (length - 1 - k).
   assign pat_pos = active_length - LEN_W'(1) - LEN_W'(cell_idx);
   assign pat_idx = pat_pos[IDX_W-1:0];
   assign in_use  = LEN_W'(cell_idx) < active_length;

   assign hit = !in_use || wildcard_mask[pat_idx]
                || (window_byte_ff == pattern[pat_idx*BYTE_W +: BYTE_W]);

   assign down_byte = window_byte_ff;

endmodule

@@ rtl/wbps_report.sv @@
// Report stage: holds the compare outcome, tracks the end of scan, drives the result register.
module wbps_report (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan_valid,
   input  wbps_pkg::scan_type            scan_item,
   output logic                          scan_take,
   input  logic [wbps_pkg::ADDR_W-1:0]   base_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wbps_pkg::rsp_type             rsp_payload
);
   import wbps_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   scan_type hold_item_ff, hold_item_in;
   logic     finished_ff, finished_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_payload_ff, rsp_payload_in;
   logic     out_free;
   logic     emit;
   logic     hold_leave;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = hold_valid_ff && !finished_ff && (hold_item_ff.match || hold_item_ff.last);
   assign hold_leave = hold_valid_ff && (!emit || out_free);
   assign scan_take  = !hold_valid_ff || hold_leave;

   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_item_in   = hold_item_ff;
      finished_in    = finished_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (scan_take) begin
         hold_valid_in = scan_valid;
         hold_item_in  = scan_item;
      end

      // Drop bytes after the first match; the last byte rearms the scan.
      if (hold_leave) begin
         finished_in = hold_item_ff.last ? 1'b0 : (finished_ff || hold_item_ff.match);
      end

      if (emit && out_free) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.found         = hold_item_ff.match;
         rsp_payload_in.match_address = hold_item_ff.match
                                        ? base_address + hold_item_ff.offset : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff   <= hold_item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
